// ===== rtl/vn_pkg.sv =====
package vn_pkg;

    localparam int COMP_W        = 24;
    localparam int SUM_W         = 2 * COMP_W;
    localparam int ROOT_W        = COMP_W;
    localparam int SQRT_STEPS    = SUM_W / 2;
    localparam int THRESH_W      = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd429;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [ROOT_W-1:0]        root_t;

    typedef struct packed {
        logic  zero;
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_pay_t;

endpackage

// ===== rtl/vn_sqrt.sv =====
module vn_sqrt
    import vn_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  sum_t     sum,
    input  vec_pay_t pay_in,
    output root_t    root,
    output vec_pay_t pay_out
);

    sum_t     n_reg    [1:SQRT_STEPS-1];
    sum_t     root_reg [1:SQRT_STEPS];
    vec_pay_t pay_reg  [1:SQRT_STEPS];

    // One digit of the root per stage, from the top bit pair down.
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam sum_t BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - s));
        sum_t     n_cur;
        sum_t     r_cur;
        vec_pay_t p_cur;
        sum_t     trial;
        logic     ge;

        if (s == 0) begin : g_first
            assign n_cur = sum;
            assign r_cur = '0;
            assign p_cur = pay_in;
        end
        else begin : g_rest
            assign n_cur = n_reg[s];
            assign r_cur = root_reg[s];
            assign p_cur = pay_reg[s];
        end

        assign trial = r_cur + BIT;
        assign ge    = n_cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s+1] <= ge ? ((r_cur >> 1) + BIT) : (r_cur >> 1);
                pay_reg[s+1]  <= p_cur;
            end
        end

        if (s < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[s+1] <= ge ? (n_cur - trial) : n_cur;
                end
            end
        end
    end

    assign root    = root_reg[SQRT_STEPS][ROOT_W-1:0];
    assign pay_out = pay_reg[SQRT_STEPS];

endmodule

// ===== rtl/vn_div_lane.sv =====
module vn_div_lane
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  en,
    input  comp_t c,
    input  root_t m,
    input  logic  zero,
    output comp_t res,
    output logic  zero_out
);

    localparam int DW = ROOT_W + FRAC_BITS + 1;
    localparam int NS = FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [DW-1:0]      rem_reg  [0:FRAC_BITS];
    root_t              m_reg    [0:FRAC_BITS];
    logic [FRAC_BITS:0] q_reg    [0:NS-1];
    logic               sat_reg  [0:NS-1];
    logic               neg_reg  [0:NS-1];
    comp_t              c_reg    [0:NS-1];
    logic               zero_reg [0:NS-1];

    logic [COMP_W-1:0]  mag;
    logic [DW-1:0]      dividend;
    logic [FRAC_BITS:0] q_sat;
    logic [DW-1:0]      q_ext;
    logic [DW-1:0]      q_signed;

    assign mag      = c[COMP_W-1] ? COMP_W'(-c) : COMP_W'(c);
    assign dividend = DW'(mag) << FRAC_BITS;

    // A quotient of two or more can only saturate, so it is flagged up front
    // and only the bits from 2^FRAC_BITS down are developed.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend;
            m_reg[0]    <= m;
            q_reg[0]    <= '0;
            sat_reg[0]  <= dividend >= (DW'(m) << (FRAC_BITS + 1));
            neg_reg[0]  <= c[COMP_W-1];
            c_reg[0]    <= c;
            zero_reg[0] <= zero;
        end
    end

    for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_bit
        localparam int K = FRAC_BITS - j;
        logic [DW-1:0]      sub;
        logic               ge;
        logic [FRAC_BITS:0] q_nx;

        assign sub = DW'(m_reg[j]) << K;
        assign ge  = rem_reg[j] >= sub;

        always_comb
        begin
            q_nx    = q_reg[j];
            q_nx[K] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]    <= q_nx;
                sat_reg[j+1]  <= sat_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                c_reg[j+1]    <= c_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end

        if (j < FRAC_BITS) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? (rem_reg[j] - sub) : rem_reg[j];
                    m_reg[j+1]   <= m_reg[j];
                end
            end
        end
    end

    assign q_sat    = (sat_reg[NS-1] || (q_reg[NS-1] > ONE)) ? ONE : q_reg[NS-1];
    assign q_ext    = DW'(q_sat);
    assign q_signed = neg_reg[NS-1] ? (~q_ext + DW'(1)) : q_ext;
    assign res      = zero_reg[NS-1] ? c_reg[NS-1] : $signed(q_signed[COMP_W-1:0]);
    assign zero_out = zero_reg[NS-1];

endmodule

// ===== rtl/vector3_normalize_core.sv =====
// Throughput: one request per cycle while in_stall is low; the square root takes one digit
// per stage and each divider lane one quotient bit per stage, all fully pipelined.
// A two-entry output stage keeps taking requests while a result waits.
// Reset clears all valid flags and loads the zero threshold thr_reg with 429.
module vector3_normalize_core
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [THRESH_W-1:0] cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  comp_t               in_x,
    input  comp_t               in_y,
    input  comp_t               in_z,
    output logic                out_valid,
    input  logic                out_stall,
    output comp_t               out_x,
    output comp_t               out_y,
    output comp_t               out_z,
    output logic                is_zero
);

    localparam int L = 2 + SQRT_STEPS + FRAC_BITS + 2;

    logic [THRESH_W-1:0] thr_reg;
    logic [L-1:0]        v_reg;
    logic                en;
    logic                in_acc;

    comp_t               ax_reg, ay_reg, az_reg;
    sum_t                sq_reg [3];
    vec_pay_t            sum_pay_reg;
    sum_t                sum_reg;

    logic [COMP_W-1:0]   mag [3];
    sum_t                sum_next;
    root_t               root;
    vec_pay_t            sq_pay;
    comp_t               p_x, p_y, p_z;
    logic                p_zero;
    logic                p_zero_x, p_zero_y, p_zero_z;

    logic                out_v_reg, skid_v_reg;
    comp_t               out_x_reg, out_y_reg, out_z_reg;
    logic                out_zero_reg;
    comp_t               skid_x_reg, skid_y_reg, skid_z_reg;
    logic                skid_zero_reg;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[L-2:0], in_acc};
        end
    end

    assign mag[0] = in_x[COMP_W-1] ? COMP_W'(-in_x) : COMP_W'(in_x);
    assign mag[1] = in_y[COMP_W-1] ? COMP_W'(-in_y) : COMP_W'(in_y);
    assign mag[2] = in_z[COMP_W-1] ? COMP_W'(-in_z) : COMP_W'(in_z);

    // Square lanes, then the sum with the zero test.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= mag[i] * mag[i];
            end
            ax_reg <= in_x;
            ay_reg <= in_y;
            az_reg <= in_z;
        end
    end

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg            <= sum_next;
            sum_pay_reg.zero   <= (sum_next < SUM_W'(thr_reg)) || (sum_next == '0);
            sum_pay_reg.x      <= ax_reg;
            sum_pay_reg.y      <= ay_reg;
            sum_pay_reg.z      <= az_reg;
        end
    end

    vn_sqrt u_sqrt (
        .clk     (clk),
        .en      (en),
        .sum     (sum_reg),
        .pay_in  (sum_pay_reg),
        .root    (root),
        .pay_out (sq_pay)
    );

    vn_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk      (clk),
        .en       (en),
        .c        (sq_pay.x),
        .m        (root),
        .zero     (sq_pay.zero),
        .res      (p_x),
        .zero_out (p_zero_x)
    );

    vn_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk      (clk),
        .en       (en),
        .c        (sq_pay.y),
        .m        (root),
        .zero     (sq_pay.zero),
        .res      (p_y),
        .zero_out (p_zero_y)
    );

    vn_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk      (clk),
        .en       (en),
        .c        (sq_pay.z),
        .m        (root),
        .zero     (sq_pay.zero),
        .res      (p_z),
        .zero_out (p_zero_z)
    );

    // All three lanes carry the same zero flag.
    assign p_zero = p_zero_x && p_zero_y && p_zero_z;

    // Output register plus skid entry; the pipeline freezes only while the skid is full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && out_stall)
        begin
            if (en && v_reg[L-1])
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= v_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && out_stall)
        begin
            if (en && v_reg[L-1])
            begin
                skid_x_reg    <= p_x;
                skid_y_reg    <= p_y;
                skid_z_reg    <= p_z;
                skid_zero_reg <= p_zero;
            end
        end
        else if (skid_v_reg)
        begin
            out_x_reg    <= skid_x_reg;
            out_y_reg    <= skid_y_reg;
            out_z_reg    <= skid_z_reg;
            out_zero_reg <= skid_zero_reg;
        end
        else
        begin
            out_x_reg    <= p_x;
            out_y_reg    <= p_y;
            out_z_reg    <= p_z;
            out_zero_reg <= p_zero;
        end
    end

    assign out_valid = out_v_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign is_zero   = out_zero_reg;

endmodule

// ===== rtl/vn_checker.sv =====
module vn_assertions
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input comp_t               out_x,
    input comp_t               out_y,
    input comp_t               out_z,
    input logic                is_zero
);

    localparam int ONE = 1 << FRAC_BITS;

    // A held result stays on the port.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The input side only stalls after a result was held at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a held result");

    // Normalized components stay within plus or minus one (checked for FRAC_BITS up to 22).
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_zero && (FRAC_BITS <= 22) |->
            ($signed(out_x) <= ONE) && ($signed(out_x) >= -ONE) &&
            ($signed(out_y) <= ONE) && ($signed(out_y) >= -ONE) &&
            ($signed(out_z) <= ONE) && ($signed(out_z) >= -ONE))
        else $error("normalized component out of range");

    // A vector that was scaled never comes out all zero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_zero |-> (out_x != 0) || (out_y != 0) || (out_z != 0))
        else $error("scaled vector is all zero");

endmodule

bind vector3_normalize_core vn_assertions #(.FRAC_BITS(FRAC_BITS)) u_vn_assertions (.*);
